// ===== rtl/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// Types, constants and command codes shared by the triangle tangent-space core.
// ----------------------------------------------------------------------------
package tts_pkg;

	localparam int FRAC_BITS = 16;
	localparam int IDX_W = 16;
	localparam int DATA_W = 32;
	localparam int MAG_W = 33;
	localparam int NORM_W = 30;
	localparam int UNIT_W = FRAC_BITS + 1;
	localparam int NUM_W = 48;
	localparam int SH_MAX = FRAC_BITS + 29;
	localparam int DVD_W = NUM_W + SH_MAX;
	localparam int DET_W = 62;
	localparam int CNT_W = 7;

	localparam int PRE_STEPS = 32;
	localparam int SQ_STEPS = 6;
	localparam int PROD_STEPS = 14;
	localparam int ROOT_STEPS = 32;
	localparam int UNIT_STEPS = UNIT_W;
	localparam int DIV_STEPS = DVD_W;

	localparam int MUL_PROD_BASE = SQ_STEPS;

	localparam logic [1:0] FS_OK = 2'd0;
	localparam logic [1:0] FS_ZERO_EDGE = 2'd1;
	localparam logic [1:0] FS_ZERO_DET = 2'd2;

	typedef struct packed {
		logic [IDX_W-1:0] vertex_index;
		logic signed [DATA_W-1:0] pos_x;
		logic signed [DATA_W-1:0] pos_y;
		logic signed [DATA_W-1:0] pos_z;
		logic signed [DATA_W-1:0] tex_u;
		logic signed [DATA_W-1:0] tex_v;
	} vertex_t;

	typedef struct packed {
		logic [IDX_W-1:0] target_index;
		logic signed [DATA_W-1:0] tangent_x;
		logic signed [DATA_W-1:0] tangent_y;
		logic signed [DATA_W-1:0] tangent_z;
		logic signed [DATA_W-1:0] bitangent_x;
		logic signed [DATA_W-1:0] bitangent_y;
		logic signed [DATA_W-1:0] bitangent_z;
		logic [1:0] frame_status;
		logic last_of_triangle;
	} frame_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SCALE,
		ST_SQ,
		ST_ROOT,
		ST_UNIT,
		ST_PROD,
		ST_DIV,
		ST_FINISH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic hold_wr;
		logic hold_slot;
		logic take_last;
		logic diff;
		logic scale;
		logic mul_go;
		logic [4:0] mul_step;
		logic root_load;
		logic root_step;
		logic unit_load;
		logic unit_step;
		logic unit_first;
		logic div_load;
		logic div_step;
		logic finish;
		logic [1:0] out_sel;
	} cmd_t;

endpackage

// ===== rtl/triangle_tangent_space_core.sv =====
// ----------------------------------------------------------------------------
// triangle_tangent_space_core
// Per-triangle tangent and bitangent from a triangle-list vertex stream.
//
// Channel   Direction  Handshake               Payload
// vertex    in         vertex_valid/stall      vertex_t, one corner
// frame     out        frame_valid/stall       frame_t, three per triangle
//
// The first two corners of a triangle are stored while the core is idle.
// The third starts the work on the triangle, the longest phase of which is
// the 93-step divider that runs six lanes side by side.
// The three results then go out in order, one request per cycle at best.
// Input is stalled from the third corner until the last result is taken.
// Reset clears the corner count and the sequencer; held corners are dropped.
// ----------------------------------------------------------------------------
module triangle_tangent_space_core import tts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic vertex_valid,
	output logic vertex_stall,
	input vertex_t vertex,
	output logic frame_valid,
	input logic frame_stall,
	output frame_t frame
);

	cmd_t cmd;

	tts_ctrl u_ctrl (
		.clk (clk),
		.arst_n (arst_n),
		.vertex_valid (vertex_valid),
		.frame_stall (frame_stall),
		.vertex_stall (vertex_stall),
		.frame_valid (frame_valid),
		.cmd (cmd)
	);

	tts_datapath u_datapath (
		.clk (clk),
		.arst_n (arst_n),
		.vertex (vertex),
		.cmd (cmd),
		.frame (frame)
	);

`ifndef SYNTH
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid |-> vertex_stall)
		else $error("Vertex request accepted while results are pending.");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !frame_stall && frame.last_of_triangle |=> !frame_valid)
		else $error("Result request continued after the last of a triangle.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid |-> (frame.frame_status == FS_OK ||
		frame.frame_status == FS_ZERO_EDGE || frame.frame_status == FS_ZERO_DET))
		else $error("Unknown frame status.");

	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame.frame_status != FS_OK |->
		frame.tangent_x == '0 && frame.bitangent_z == '0)
		else $error("Degenerate triangle produced a nonzero vector.");
`endif

endmodule

// ===== rtl/tts_ctrl.sv =====
// ----------------------------------------------------------------------------
// tts_ctrl
// Sequencer that collects three corners and steps the datapath through
// prescale, squares, root, normalize, products, divide, three result requests.
// ----------------------------------------------------------------------------
module tts_ctrl import tts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic vertex_valid,
	input logic frame_stall,
	output logic vertex_stall,
	output logic frame_valid,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0] cc_q, cc_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			cc_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			cc_q <= cc_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cc_d = cc_q;
		cmd = '0;
		vertex_stall = 1'b1;
		frame_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				vertex_stall = 1'b0;
				if (vertex_valid) begin
					if (cc_q != 2'd2) begin
						cmd.hold_wr = 1'b1;
						cmd.hold_slot = cc_q[0];
						cc_d = cc_q + 2'd1;
					end else begin
						cmd.take_last = 1'b1;
						cc_d = '0;
						state_d = ST_DIFF;
					end
				end
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				cnt_d = '0;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				if (cnt_q == CNT_W'(PRE_STEPS - 1)) begin
					cnt_d = '0;
					state_d = ST_SQ;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_SQ: begin
				cmd.mul_step = cnt_q[4:0];
				if (cnt_q == CNT_W'(SQ_STEPS)) begin
					cnt_d = '0;
					state_d = ST_ROOT;
				end else begin
					cmd.mul_go = 1'b1;
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_ROOT: begin
				cmd.root_load = (cnt_q == '0);
				cmd.root_step = (cnt_q != '0);
				if (cnt_q == CNT_W'(ROOT_STEPS)) begin
					cnt_d = '0;
					state_d = ST_UNIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_UNIT: begin
				cmd.unit_load = (cnt_q == '0);
				cmd.unit_step = (cnt_q != '0);
				cmd.unit_first = (cnt_q == CNT_W'(1));
				if (cnt_q == CNT_W'(UNIT_STEPS)) begin
					cnt_d = '0;
					state_d = ST_PROD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_PROD: begin
				cmd.mul_step = 5'(MUL_PROD_BASE) + cnt_q[4:0];
				if (cnt_q == CNT_W'(PROD_STEPS)) begin
					cnt_d = '0;
					state_d = ST_DIV;
				end else begin
					cmd.mul_go = 1'b1;
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_load = (cnt_q == '0);
				cmd.div_step = (cnt_q != '0);
				if (cnt_q == CNT_W'(DIV_STEPS)) begin
					cnt_d = '0;
					state_d = ST_FINISH;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				cnt_d = '0;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				frame_valid = 1'b1;
				cmd.out_sel = cnt_q[1:0];
				if (!frame_stall) begin
					if (cnt_q == CNT_W'(2)) begin
						cnt_d = '0;
						state_d = ST_IDLE;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
				cnt_d = '0;
			end
		endcase
	end

endmodule

// ===== rtl/tts_datapath.sv =====
// ----------------------------------------------------------------------------
// tts_datapath
// Corner storage, edge and UV deltas, prescaler, shared multiplier with
// accumulators, two root lanes, six normalize lanes and six final divide lanes.
// ----------------------------------------------------------------------------
module tts_datapath import tts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input vertex_t vertex,
	input cmd_t cmd,
	output frame_t frame
);

	vertex_t hold_q [2];
	vertex_t last_q;

	logic signed [MAG_W-1:0] dif [10];
	logic neg_q [10];
	logic [MAG_W-1:0] pm_q [10];
	logic edge_zero_q, uv_zero_q;
	logic signed [5:0] k_q;

	logic [MAG_W-1:0] org [3];
	logic hi [3];
	logic lo [3];

	logic signed [DATA_W-1:0] sqo [6];
	logic signed [DATA_W-1:0] dso [4];
	logic signed [DATA_W-1:0] eo [6];
	logic signed [UNIT_W:0] eu [6];
	logic signed [DATA_W-1:0] ma, mb;
	logic signed [63:0] prod;
	logic [3:0] mtgt;
	logic mfirst, msub;

	logic signed [63:0] prod_s1;
	logic [3:0] tgt_s1;
	logic first_s1, sub_s1, mv_s1;
	logic signed [63:0] acc_q [9];

	logic [63:0] rn_q [2];
	logic [63:0] rres_q [2];
	logic [63:0] rbit_q;
	logic [63:0] rt [2];

	logic [MAG_W-1:0] ur_q [6];
	logic [UNIT_W-1:0] uq_q [6];
	logic [MAG_W-1:0] urs [6];
	logic [MAG_W-1:0] udiv [6];
	logic uge [6];

	logic [DVD_W-1:0] fn_q [6];
	logic [DET_W-1:0] frem_q [6];
	logic [DATA_W-1:0] fq_q [6];
	logic fsat_q [6];
	logic fneg_q [6];
	logic [DET_W-1:0] bmag_q;
	logic [DET_W:0] frs [6];
	logic fge [6];
	logic [DATA_W:0] fqn [6];
	logic [63:0] fabs [6];
	logic [63:0] dabs;
	logic [6:0] sh_sum;
	logic [5:0] sh;

	logic [1:0] status_q;
	logic signed [DATA_W-1:0] res_q [6];
	logic signed [DATA_W-1:0] fval [6];
	logic [1:0] status_w;

	always_ff @(posedge clk) begin
		if (cmd.hold_wr) begin
			hold_q[cmd.hold_slot] <= vertex;
		end
		if (cmd.take_last) begin
			last_q <= vertex;
		end
	end

	always_comb begin
		dif[0] = MAG_W'(hold_q[1].pos_x) - MAG_W'(hold_q[0].pos_x);
		dif[1] = MAG_W'(hold_q[1].pos_y) - MAG_W'(hold_q[0].pos_y);
		dif[2] = MAG_W'(hold_q[1].pos_z) - MAG_W'(hold_q[0].pos_z);
		dif[3] = MAG_W'(last_q.pos_x) - MAG_W'(hold_q[0].pos_x);
		dif[4] = MAG_W'(last_q.pos_y) - MAG_W'(hold_q[0].pos_y);
		dif[5] = MAG_W'(last_q.pos_z) - MAG_W'(hold_q[0].pos_z);
		dif[6] = MAG_W'(hold_q[1].tex_u) - MAG_W'(hold_q[0].tex_u);
		dif[7] = MAG_W'(hold_q[1].tex_v) - MAG_W'(hold_q[0].tex_v);
		dif[8] = MAG_W'(last_q.tex_u) - MAG_W'(hold_q[0].tex_u);
		dif[9] = MAG_W'(last_q.tex_v) - MAG_W'(hold_q[0].tex_v);
	end

	always_comb begin
		org[0] = pm_q[0] | pm_q[1] | pm_q[2];
		org[1] = pm_q[3] | pm_q[4] | pm_q[5];
		org[2] = pm_q[6] | pm_q[7] | pm_q[8] | pm_q[9];
		for (int g = 0; g < 3; g++) begin
			hi[g] = |org[g][MAG_W-1:NORM_W];
			lo[g] = (org[g] != '0) && !(|org[g][MAG_W-1:NORM_W-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			for (int i = 0; i < 10; i++) begin
				neg_q[i] <= dif[i][MAG_W-1];
				pm_q[i] <= dif[i][MAG_W-1] ? MAG_W'(-dif[i]) : MAG_W'(dif[i]);
			end
			edge_zero_q <= (dif[0] == '0 && dif[1] == '0 && dif[2] == '0) ||
				(dif[3] == '0 && dif[4] == '0 && dif[5] == '0);
			uv_zero_q <= dif[6] == '0 && dif[7] == '0 && dif[8] == '0 && dif[9] == '0;
			k_q <= '0;
		end else if (cmd.scale) begin
			for (int i = 0; i < 10; i++) begin
				if (hi[(i < 3) ? 0 : ((i < 6) ? 1 : 2)]) begin
					pm_q[i] <= pm_q[i] >> 1;
				end else if (lo[(i < 3) ? 0 : ((i < 6) ? 1 : 2)]) begin
					pm_q[i] <= pm_q[i] << 1;
				end
			end
			if (hi[2]) begin
				k_q <= k_q - 6'sd1;
			end else if (lo[2]) begin
				k_q <= k_q + 6'sd1;
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			sqo[j] = $signed({2'b00, pm_q[j][NORM_W-1:0]});
			eu[j] = neg_q[j] ? -$signed({1'b0, uq_q[j]}) : $signed({1'b0, uq_q[j]});
			eo[j] = DATA_W'(eu[j]);
		end
		for (int j = 0; j < 4; j++) begin
			dso[j] = neg_q[6 + j] ? -$signed({2'b00, pm_q[6 + j][NORM_W-1:0]}) :
				$signed({2'b00, pm_q[6 + j][NORM_W-1:0]});
		end
	end

	always_comb begin
		ma = sqo[0];
		mb = sqo[0];
		mtgt = 4'd0;
		mfirst = 1'b0;
		msub = 1'b0;
		case (cmd.mul_step)
			5'd0: begin ma = sqo[0]; mb = sqo[0]; mtgt = 4'd0; mfirst = 1'b1; end
			5'd1: begin ma = sqo[1]; mb = sqo[1]; mtgt = 4'd0; end
			5'd2: begin ma = sqo[2]; mb = sqo[2]; mtgt = 4'd0; end
			5'd3: begin ma = sqo[3]; mb = sqo[3]; mtgt = 4'd1; mfirst = 1'b1; end
			5'd4: begin ma = sqo[4]; mb = sqo[4]; mtgt = 4'd1; end
			5'd5: begin ma = sqo[5]; mb = sqo[5]; mtgt = 4'd1; end
			5'd6: begin ma = dso[0]; mb = dso[3]; mtgt = 4'd2; mfirst = 1'b1; end
			5'd7: begin ma = dso[1]; mb = dso[2]; mtgt = 4'd2; msub = 1'b1; end
			5'd8: begin ma = dso[3]; mb = eo[0]; mtgt = 4'd3; mfirst = 1'b1; end
			5'd9: begin ma = dso[1]; mb = eo[3]; mtgt = 4'd3; msub = 1'b1; end
			5'd10: begin ma = dso[3]; mb = eo[1]; mtgt = 4'd4; mfirst = 1'b1; end
			5'd11: begin ma = dso[1]; mb = eo[4]; mtgt = 4'd4; msub = 1'b1; end
			5'd12: begin ma = dso[3]; mb = eo[2]; mtgt = 4'd5; mfirst = 1'b1; end
			5'd13: begin ma = dso[1]; mb = eo[5]; mtgt = 4'd5; msub = 1'b1; end
			5'd14: begin ma = dso[0]; mb = eo[3]; mtgt = 4'd6; mfirst = 1'b1; end
			5'd15: begin ma = dso[2]; mb = eo[0]; mtgt = 4'd6; msub = 1'b1; end
			5'd16: begin ma = dso[0]; mb = eo[4]; mtgt = 4'd7; mfirst = 1'b1; end
			5'd17: begin ma = dso[2]; mb = eo[1]; mtgt = 4'd7; msub = 1'b1; end
			5'd18: begin ma = dso[0]; mb = eo[5]; mtgt = 4'd8; mfirst = 1'b1; end
			5'd19: begin ma = dso[2]; mb = eo[2]; mtgt = 4'd8; msub = 1'b1; end
			default: begin ma = sqo[0]; mb = sqo[0]; mtgt = 4'd0; end
		endcase
	end

	assign prod = ma * mb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_s1 <= 1'b0;
		end else begin
			mv_s1 <= cmd.mul_go;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		tgt_s1 <= mtgt;
		first_s1 <= mfirst;
		sub_s1 <= msub;
		if (mv_s1) begin
			if (first_s1) begin
				acc_q[tgt_s1] <= prod_s1;
			end else if (sub_s1) begin
				acc_q[tgt_s1] <= acc_q[tgt_s1] - prod_s1;
			end else begin
				acc_q[tgt_s1] <= acc_q[tgt_s1] + prod_s1;
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			rt[l] = rres_q[l] + rbit_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.root_load) begin
			for (int l = 0; l < 2; l++) begin
				rn_q[l] <= 64'(acc_q[l]);
				rres_q[l] <= '0;
			end
			rbit_q <= 64'h4000_0000_0000_0000;
		end else if (cmd.root_step) begin
			for (int l = 0; l < 2; l++) begin
				if (rn_q[l] >= rt[l]) begin
					rn_q[l] <= rn_q[l] - rt[l];
					rres_q[l] <= (rres_q[l] >> 1) + rbit_q;
				end else begin
					rres_q[l] <= rres_q[l] >> 1;
				end
			end
			rbit_q <= rbit_q >> 2;
		end
	end

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			udiv[j] = {1'b0, rres_q[(j < 3) ? 0 : 1][MAG_W-2:0]};
			urs[j] = cmd.unit_first ? ur_q[j] : (ur_q[j] << 1);
			uge[j] = urs[j] >= udiv[j];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.unit_load) begin
			for (int j = 0; j < 6; j++) begin
				ur_q[j] <= {3'b000, pm_q[j][NORM_W-1:0]};
				uq_q[j] <= '0;
			end
		end else if (cmd.unit_step) begin
			for (int j = 0; j < 6; j++) begin
				ur_q[j] <= uge[j] ? (urs[j] - udiv[j]) : urs[j];
				uq_q[j] <= {uq_q[j][UNIT_W-2:0], uge[j]};
			end
		end
	end

	always_comb begin
		sh_sum = 7'(FRAC_BITS) + {k_q[5], k_q};
		sh = sh_sum[5:0];
		dabs = acc_q[2][63] ? 64'(-acc_q[2]) : 64'(acc_q[2]);
		for (int i = 0; i < 6; i++) begin
			fabs[i] = acc_q[3 + i][63] ? 64'(-acc_q[3 + i]) : 64'(acc_q[3 + i]);
			frs[i] = {frem_q[i], fn_q[i][DVD_W-1]};
			fge[i] = frs[i] >= {1'b0, bmag_q};
			fqn[i] = {fq_q[i], fge[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			bmag_q <= dabs[DET_W-1:0];
			for (int i = 0; i < 6; i++) begin
				fn_q[i] <= DVD_W'(fabs[i][NUM_W-1:0]) << sh;
				frem_q[i] <= '0;
				fq_q[i] <= '0;
				fsat_q[i] <= 1'b0;
				fneg_q[i] <= acc_q[3 + i][63] ^ acc_q[2][63];
			end
		end else if (cmd.div_step) begin
			for (int i = 0; i < 6; i++) begin
				frem_q[i] <= fge[i] ? DET_W'(frs[i] - {1'b0, bmag_q}) : frs[i][DET_W-1:0];
				fn_q[i] <= fn_q[i] << 1;
				fq_q[i] <= fqn[i][DATA_W-1:0];
				if (|fqn[i][DATA_W:DATA_W-1]) begin
					fsat_q[i] <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		if (edge_zero_q) begin
			status_w = FS_ZERO_EDGE;
		end else if (uv_zero_q || acc_q[2] == '0) begin
			status_w = FS_ZERO_DET;
		end else begin
			status_w = FS_OK;
		end
		for (int i = 0; i < 6; i++) begin
			if (fsat_q[i]) begin
				fval[i] = fneg_q[i] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			end else begin
				fval[i] = fneg_q[i] ? -$signed(fq_q[i]) : $signed(fq_q[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q <= status_w;
			for (int i = 0; i < 6; i++) begin
				res_q[i] <= (status_w == FS_OK) ? fval[i] : '0;
			end
		end
	end

	always_comb begin
		case (cmd.out_sel)
			2'd0: frame.target_index = hold_q[0].vertex_index;
			2'd1: frame.target_index = hold_q[1].vertex_index;
			default: frame.target_index = last_q.vertex_index;
		endcase
		frame.tangent_x = res_q[0];
		frame.tangent_y = res_q[1];
		frame.tangent_z = res_q[2];
		frame.bitangent_x = res_q[3];
		frame.bitangent_y = res_q[4];
		frame.bitangent_z = res_q[5];
		frame.frame_status = status_q;
		frame.last_of_triangle = (cmd.out_sel == 2'd2);
	end

endmodule
